// File: sv/adam_wu_pkg.sv
package adam_wu_pkg;

  localparam int NUM_WEIGHTS = 1024;
  localparam int IDX_W       = $clog2(NUM_WEIGHTS);

  localparam int WEIGHT_W  = 32;
  localparam int MOM1_W    = 32;
  localparam int MOM2_W    = 64;
  localparam int POWER_W   = 33;
  localparam int LR_W      = 24;
  localparam int BETA_W    = 16;
  localparam int EPS_W     = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [LR_W-1:0]   LR_RESET    = 24'd16777;
  localparam logic [BETA_W-1:0] BETA1_RESET = 16'd58982;
  localparam logic [BETA_W-1:0] BETA2_RESET = 16'd65470;
  localparam logic [EPS_W-1:0]  EPS_RESET   = 8'd1;

  // 1.0 in Q1.32
  localparam logic [POWER_W-1:0] POWER_ONE = 33'h1_0000_0000;
  // Largest step magnitude, 2^34 in Q8.24
  localparam logic [34:0] STEP_CAP = 35'h4_0000_0000;

  typedef enum logic [1:0] {
    REG_STEP_SIZE     = 2'd0,
    REG_BETA_FIRST    = 2'd1,
    REG_BETA_SECOND   = 2'd2,
    REG_EPSILON       = 2'd3
  } reg_idx_t;

endpackage

// File: sv/adam_wu_if.sv
interface adam_wu_in_if;
  import adam_wu_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [IDX_W-1:0]           element_index;
  logic signed [WEIGHT_W-1:0] gradient;
  logic signed [WEIGHT_W-1:0] current_weight;
  logic                       first_of_step;

  modport source (output valid, element_index, gradient, current_weight, first_of_step,
                  input ready);
  modport sink (input valid, element_index, gradient, current_weight, first_of_step,
                output ready);
endinterface

interface adam_wu_out_if;
  import adam_wu_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] new_weight;

  modport source (output valid, new_weight, input ready);
  modport sink (input valid, new_weight, output ready);
endinterface

interface adam_wu_cfg_if;
  import adam_wu_pkg::*;
  logic                  valid;
  logic                  ready;
  reg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/adam_wu_ram.sv
module adam_wu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/adam_weight_update.sv
// Channel  Direction  Payload
// in_ch    sink       element_index, gradient, current_weight, first_of_step
// out_ch   source     new_weight
// cfg_ch   sink       index, data (step size, beta_first, beta_second, epsilon)
//
// One item at a time. An item whose update is skipped goes from the write state
// straight to output; a full update runs up to four 96-step passes of the shared
// radix-2 divider (the second moment pass is left out when its correction saturates)
// and 32 steps of the square root. After reset a clearing pass writes zero to all 1024
// moment entries before the first item is accepted; configuration writes are taken throughout.
// A result waits in the output register; the next item is accepted meanwhile, and
// it stalls in its last state while that register is still full.
module adam_weight_update (
  input logic          clk,
  input logic          rst_n,
  adam_wu_in_if.sink   in_ch,
  adam_wu_out_if.source out_ch,
  adam_wu_cfg_if.sink  cfg_ch
);
  import adam_wu_pkg::*;

  localparam int MEM_W = MOM1_W + MOM2_W;

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001,
    S_IDLE = 16'h0002,
    S_RD   = 16'h0004,
    S_M1   = 16'h0008,
    S_M2   = 16'h0010,
    S_V1   = 16'h0020,
    S_V2   = 16'h0040,
    S_WR   = 16'h0080,
    S_DMH  = 16'h0100,
    S_DVH  = 16'h0200,
    S_SQ   = 16'h0400,
    S_DQ   = 16'h0800,
    S_LR   = 16'h1000,
    S_DLR  = 16'h2000,
    S_FIN  = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  // Control registers
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [LR_W-1:0]     lr_r, lr_nxt;
  logic [BETA_W-1:0]   b1_r, b1_nxt, b2_r, b2_nxt;
  logic [EPS_W-1:0]    eps_r, eps_nxt;
  logic [POWER_W-1:0]  p1_r, p1_nxt, p2_r, p2_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic signed [WEIGHT_W-1:0] g_r, g_nxt, w_r, w_nxt;
  logic                       first_r, first_nxt;
  logic [63:0]                g2_r, g2_nxt;
  logic signed [48:0]         ma_r, ma_nxt;
  logic signed [MOM1_W-1:0]   m_r, m_nxt;
  logic [79:0]                va_r, va_nxt;
  logic [MOM2_W-1:0]          v_r, v_nxt;
  logic [95:0]                num_r, num_nxt;
  logic [32:0]                den_r, den_nxt;
  logic [32:0]                rem_r, rem_nxt;
  logic [63:0]                mhat_r, mhat_nxt;
  logic [63:0]                sx_r, sx_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic [58:0]                lrq_r, lrq_nxt;
  logic                       sat_r, sat_nxt;
  logic signed [WEIGHT_W-1:0] res_r, res_nxt;
  logic signed [WEIGHT_W-1:0] out_w_r, out_w_nxt;

  // Memory
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;
  logic signed [MOM1_W-1:0] rd_m;
  logic [MOM2_W-1:0]        rd_v;

  // Datapath intermediates
  logic [16:0]        k1, k2;
  logic [31:0]        gmag, mmag;
  logic [48:0]        p1_prod, p2_prod;
  logic signed [50:0] msum;
  logic [81:0]        vsum;
  logic [32:0]        c1, c2;
  logic [33:0]        rem_sh;
  logic               div_ge;
  logic [63:0]        trial;
  logic               sq_ge;
  logic [32:0]        d_sum;
  logic [59:0]        step_sum;
  logic [34:0]        step;
  logic signed [35:0] step_s, res_wide;

  adam_wu_ram #(
    .WIDTH(MEM_W),
    .DEPTH(NUM_WEIGHTS)
  ) u_mom_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_m = $signed(ram_rdata[MEM_W-1:MOM2_W]);
  assign rd_v = ram_rdata[MOM2_W-1:0];

  assign in_ch.ready   = (state_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.new_weight = out_w_r;

  always_comb begin
    k1      = 17'(18'h10000 - 18'(b1_r));
    k2      = 17'(18'h10000 - 18'(b2_r));
    gmag    = g_r[WEIGHT_W-1] ? 32'(-g_r) : 32'(g_r);
    mmag    = m_r[MOM1_W-1] ? 32'(-m_r) : 32'(m_r);
    p1_prod = 49'(p1_r) * 49'(b1_r);
    p2_prod = 49'(p2_r) * 49'(b2_r);
    msum    = 51'(ma_r) + $signed({1'b0, k1}) * 51'(g_r);
    vsum    = 82'(va_r) + 82'(g2_r) * 82'(k2);
    c1      = 33'(34'(POWER_ONE) - 34'(p1_r));
    c2      = 33'(34'(POWER_ONE) - 34'(p2_r));

    // One restoring division step: the quotient shifts into num_r from below.
    rem_sh  = {rem_r, num_r[95]};
    div_ge  = rem_sh >= {1'b0, den_r};

    // One step of the bit-serial integer square root.
    trial   = sres_r + sbit_r;
    sq_ge   = sx_r >= trial;

    // The root is complete only after the last step, so take it from the next value.
    d_sum    = 33'(sres_nxt[31:0]) + 33'(eps_r);
    step_sum = 60'(lrq_r) + 60'(num_r[23:0]);
    step     = (sat_r || step_sum > 60'(STEP_CAP)) ? STEP_CAP : step_sum[34:0];
    step_s   = $signed({1'b0, step});
    res_wide = (m_r > 0) ? 36'(w_r) - step_s : 36'(w_r) + step_s;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    lr_nxt        = lr_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    eps_nxt       = eps_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    g_nxt         = g_r;
    w_nxt         = w_r;
    first_nxt     = first_r;
    g2_nxt        = g2_r;
    ma_nxt        = ma_r;
    m_nxt         = m_r;
    va_nxt        = va_r;
    v_nxt         = v_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    mhat_nxt      = mhat_r;
    sx_nxt        = sx_r;
    sres_nxt      = sres_r;
    sbit_nxt      = sbit_r;
    lrq_nxt       = lrq_r;
    sat_nxt       = sat_r;
    res_nxt       = res_r;
    out_w_nxt     = out_w_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {m_r, v_r};
    ram_raddr     = idx_r;

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_STEP_SIZE:     lr_nxt  = cfg_ch.data[LR_W-1:0];
        REG_BETA_FIRST:    b1_nxt  = cfg_ch.data[BETA_W-1:0];
        REG_BETA_SECOND:   b2_nxt  = cfg_ch.data[BETA_W-1:0];
        REG_EPSILON:       eps_nxt = cfg_ch.data[EPS_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Shared divider stepping, used by all four division states.
    if (state_r == S_DMH || state_r == S_DVH || state_r == S_DQ || state_r == S_DLR) begin
      rem_nxt = div_ge ? 33'(rem_sh - {1'b0, den_r}) : rem_sh[32:0];
      num_nxt = {num_r[94:0], div_ge};
      cnt_nxt = cnt_r - 7'd1;
    end

    unique case (state_r)
      S_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(NUM_WEIGHTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = in_ch.element_index;
        if (in_ch.valid) begin
          idx_nxt   = in_ch.element_index;
          g_nxt     = in_ch.gradient;
          w_nxt     = in_ch.current_weight;
          first_nxt = in_ch.first_of_step;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        g2_nxt = 64'(gmag) * 64'(gmag);
        if (first_r) begin
          p1_nxt = p1_prod[48:16];
          p2_nxt = p2_prod[48:16];
        end
        state_nxt = S_M1;
      end
      S_M1: begin
        ma_nxt    = $signed({1'b0, b1_r}) * rd_m;
        state_nxt = S_M2;
      end
      S_M2: begin
        // Arithmetic shift gives the floor of the division by 2^16.
        m_nxt     = msum[47:16];
        state_nxt = S_V1;
      end
      S_V1: begin
        va_nxt    = 80'(rd_v) * 80'(b2_r);
        state_nxt = S_V2;
      end
      S_V2: begin
        v_nxt     = vsum[79:16];
        state_nxt = S_WR;
      end
      S_WR: begin
        ram_we = 1'b1;
        if (c1 == '0 || c2 == '0 || m_r == '0) begin
          res_nxt   = w_r;
          state_nxt = S_OUT;
        end else begin
          num_nxt   = {32'd0, mmag, 32'd0};
          den_nxt   = c1;
          rem_nxt   = '0;
          cnt_nxt   = 7'd95;
          state_nxt = S_DMH;
        end
      end
      S_DMH: begin
        if (cnt_r == '0) begin
          mhat_nxt = num_nxt[63:0];
          // The bias-corrected second moment saturates when v / c2 reaches 2^32.
          if ({1'b0, v_r} >= {c2, 32'd0}) begin
            sx_nxt    = '1;
            sres_nxt  = '0;
            sbit_nxt  = 64'h4000_0000_0000_0000;
            cnt_nxt   = 7'd31;
            state_nxt = S_SQ;
          end else begin
            num_nxt   = {v_r, 32'd0};
            den_nxt   = c2;
            rem_nxt   = '0;
            cnt_nxt   = 7'd95;
            state_nxt = S_DVH;
          end
        end
      end
      S_DVH: begin
        if (cnt_r == '0) begin
          sx_nxt    = num_nxt[63:0];
          sres_nxt  = '0;
          sbit_nxt  = 64'h4000_0000_0000_0000;
          cnt_nxt   = 7'd31;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (sq_ge) begin
          sx_nxt   = sx_r - trial;
          sres_nxt = (sres_r >> 1) + sbit_r;
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        cnt_nxt  = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          state_nxt = S_DQ;
        end
      end
      S_DQ: begin
        if (cnt_r == '0) begin
          state_nxt = S_LR;
        end
      end
      S_LR: begin
        lrq_nxt   = 59'(lr_r) * 59'(num_r[34:0]);
        sat_nxt   = (lr_r != '0) && (num_r[63:35] != '0);
        num_nxt   = 96'(57'(lr_r) * 57'(rem_r));
        rem_nxt   = '0;
        cnt_nxt   = 7'd95;
        state_nxt = S_DLR;
      end
      S_DLR: begin
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_wide > 36'sh0_7FFF_FFFF) begin
          res_nxt = 32'sh7FFF_FFFF;
        end else if (res_wide < -36'sh0_8000_0000) begin
          res_nxt = 32'sh8000_0000;
        end else begin
          res_nxt = res_wide[31:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_w_nxt     = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase

    // The quotient register feeds the next division as its numerator.
    if (state_r == S_SQ && cnt_r == '0) begin
      num_nxt = {32'd0, mhat_r};
      den_nxt = (d_sum == '0) ? 33'd1 : d_sum;
      rem_nxt = '0;
      cnt_nxt = 7'd95;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      lr_r        <= LR_RESET;
      b1_r        <= BETA1_RESET;
      b2_r        <= BETA2_RESET;
      eps_r       <= EPS_RESET;
      p1_r        <= POWER_ONE;
      p2_r        <= POWER_ONE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      lr_r        <= lr_nxt;
      b1_r        <= b1_nxt;
      b2_r        <= b2_nxt;
      eps_r       <= eps_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    g_r     <= g_nxt;
    w_r     <= w_nxt;
    first_r <= first_nxt;
    g2_r    <= g2_nxt;
    ma_r    <= ma_nxt;
    m_r     <= m_nxt;
    va_r    <= va_nxt;
    v_r     <= v_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    mhat_r  <= mhat_nxt;
    sx_r    <= sx_nxt;
    sres_r  <= sres_nxt;
    sbit_r  <= sbit_nxt;
    lrq_r   <= lrq_nxt;
    sat_r   <= sat_nxt;
    res_r   <= res_nxt;
    out_w_r <= out_w_nxt;
  end

endmodule
